[rtl/vcbd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vcbd_pkg
// Shared types, codes and constants of the video capture block DMA.
// ----------------------------------------------------------------------------
package vcbd_pkg;

    // Default geometry of the capture ring
    localparam int WORDS_PER_BLOCK_DEF = 16;
    localparam int BLOCKS_DEF          = 2;

    // Field widths
    localparam int ADDR_W    = 32;
    localparam int WORD_W    = 32;
    localparam int FBYTES_W  = 24;
    localparam int PIXEL_W   = 8;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [ADDR_W-1:0]   DEST_ADDR_RST   = 32'h0000_0000;
    localparam logic [FBYTES_W-1:0] FRAME_BYTES_RST = 24'h04_B000;
    localparam logic [ADDR_W-1:0]   RAM_END_RST     = 32'hFFFF_FFFF;

    // Request kinds carried on the slave tuser
    typedef enum logic [1:0] {
        REQ_PIXEL = 2'd0,
        REQ_ARM   = 2'd1,
        REQ_DRAIN = 2'd2
    } t_req;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEST_ADDR   = 2'd0,
        CFG_FRAME_BYTES = 2'd1,
        CFG_RAM_END     = 2'd2
    } t_cfg_idx;

    // Register file contents handed to the controller
    typedef struct packed {
        logic [ADDR_W-1:0]   dest_addr;
        logic [FBYTES_W-1:0] frame_bytes;
        logic [ADDR_W-1:0]   ram_end;
    } t_cfg;

endpackage
`default_nettype wire

[rtl/vcbd_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vcbd_store
// Word store of the capture ring: one write port, one registered read port.
// ----------------------------------------------------------------------------
module vcbd_store #(
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [31:0]              i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [31:0]              o_rd_data
);
    import vcbd_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

[rtl/vcbd_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vcbd_ctrl
// Pixel packing, arm handling, ring pointers and burst read-out of the store.
// ----------------------------------------------------------------------------
module vcbd_ctrl #(
    parameter int WORDS_PER_BLOCK = 16,
    parameter int BLOCKS          = 2
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire vcbd_pkg::t_cfg                            i_cfg,
    // request stream
    input  wire logic                                      i_s_tvalid,
    output logic                                           o_s_tready,
    input  wire logic [15:0]                               i_s_tdata,
    input  wire logic [1:0]                                i_s_tuser,
    // write stream
    output logic                                           o_m_tvalid,
    input  wire logic                                      i_m_tready,
    output logic      [63:0]                               o_m_tdata,
    output logic                                           o_m_tlast,
    output logic                                           o_m_tuser,
    // store ports
    output logic                                           o_wr_en,
    output logic [$clog2(WORDS_PER_BLOCK*BLOCKS)-1:0]      o_wr_addr,
    output logic [31:0]                                    o_wr_data,
    output logic                                           o_rd_en,
    output logic [$clog2(WORDS_PER_BLOCK*BLOCKS)-1:0]      o_rd_addr,
    input  wire logic [31:0]                               i_rd_data
);
    import vcbd_pkg::*;

    localparam int STORE_WORDS = WORDS_PER_BLOCK * BLOCKS;
    localparam int AW          = $clog2(STORE_WORDS);
    localparam int BW          = $clog2(BLOCKS);
    localparam int CW          = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;
    localparam int LW          = $clog2(WORDS_PER_BLOCK + 1);
    localparam logic [ADDR_W-1:0] BURST_BYTES = ADDR_W'(4 * WORDS_PER_BLOCK);
    localparam logic [AW-1:0] LAST_WORD  = AW'(STORE_WORDS - 1);
    localparam logic [AW-1:0] BLOCK_STEP = AW'(WORDS_PER_BLOCK);
    localparam logic [BW-1:0] LAST_BLOCK = BW'(BLOCKS - 1);
    localparam logic [CW-1:0] LAST_WIB   = CW'(WORDS_PER_BLOCK - 1);
    localparam logic [LW-1:0] BURST_LEN  = LW'(WORDS_PER_BLOCK);

    typedef enum logic {
        ST_IDLE,
        ST_BURST
    } t_state;

    // Control state
    t_state              r_state,        n_state;
    logic [1:0]          r_lane,         n_lane;
    logic [AW-1:0]       r_fill_word,    n_fill_word;
    logic [CW-1:0]       r_fill_wib,     n_fill_wib;
    logic [BW-1:0]       r_fill_block,   n_fill_block;
    logic [BW-1:0]       r_drain_block,  n_drain_block;
    logic [AW-1:0]       r_drain_base,   n_drain_base;
    logic                r_armed,        n_armed;
    logic                r_need,         n_need;
    logic                r_started,      n_started;
    logic                r_frame_active, n_frame_active;
    logic [ADDR_W-1:0]   r_next_addr,    n_next_addr;
    logic [ADDR_W-1:0]   r_frame_start,  n_frame_start;
    logic [LW-1:0]       r_rd_left,      n_rd_left;
    logic                r_rd_pend,      n_rd_pend;
    logic                r_out_valid,    n_out_valid;
    // Payload
    logic [23:0]         r_asm,          n_asm;
    logic [AW-1:0]       r_rd_ptr,       n_rd_ptr;
    logic [ADDR_W-1:0]   r_rd_addr,      n_rd_addr;
    logic [ADDR_W-1:0]   r_pend_addr,    n_pend_addr;
    logic                r_pend_last,    n_pend_last;
    logic                r_burst_done,   n_burst_done;
    logic [ADDR_W-1:0]   r_out_addr,     n_out_addr;
    logic [WORD_W-1:0]   r_out_data,     n_out_data;
    logic                r_out_last,     n_out_last;
    logic                r_out_done,     n_out_done;

    // Request decode
    logic               accept, is_pix, is_arm, is_drn;
    logic               fv, lv;
    logic [PIXEL_W-1:0] px;
    logic               fa_upd, armed_upd, arm_take;
    logic               need_a, started_a;
    logic [ADDR_W-1:0]  na_a, fs_a, next_end, span;
    logic [ADDR_W:0]    end_sum;
    logic               drain_go, done;
    logic               load_out, issue;

    assign fv = i_s_tdata[0];
    assign lv = i_s_tdata[1];
    assign px = i_s_tdata[9:2];

    assign accept = i_s_tvalid && (r_state == ST_IDLE);
    assign is_pix = accept && (i_s_tuser == REQ_PIXEL);
    assign is_arm = accept && (i_s_tuser == REQ_ARM);
    assign is_drn = accept && (i_s_tuser == REQ_DRAIN);

    // Arm check sees the frame flag and arm request of this transaction
    assign fa_upd    = is_pix ? fv : r_frame_active;
    assign armed_upd = is_arm ? 1'b1 : r_armed;
    assign arm_take  = (is_pix || is_arm || is_drn) && armed_upd && r_need && !fa_upd;
    assign need_a    = arm_take ? 1'b0 : r_need;
    assign started_a = arm_take || r_started;
    assign na_a      = arm_take ? i_cfg.dest_addr : r_next_addr;
    assign fs_a      = arm_take ? i_cfg.dest_addr : r_frame_start;

    // Drain decision and completion test
    assign drain_go = is_drn && started_a && !need_a && (r_drain_block != r_fill_block);
    assign next_end = na_a + BURST_BYTES;
    assign end_sum  = {1'b0, next_end} + {1'b0, BURST_BYTES};
    assign span     = next_end - fs_a;
    assign done     = (end_sum > {1'b0, i_cfg.ram_end}) ||
                      (span >= {{(ADDR_W-FBYTES_W){1'b0}}, i_cfg.frame_bytes});

    // Burst read pipeline: store read, then output register
    assign load_out = r_rd_pend && (!r_out_valid || i_m_tready);
    assign issue    = (r_state == ST_BURST) && (r_rd_left != '0) && (!r_rd_pend || load_out);

    // Store access
    assign o_wr_en   = is_pix && fv && lv && (r_lane == 2'd3);
    assign o_wr_addr = r_fill_word;
    assign o_wr_data = {px, r_asm};
    assign o_rd_en   = issue;
    assign o_rd_addr = r_rd_ptr;

    // Next state
    always_comb begin
        n_state        = r_state;
        n_lane         = r_lane;
        n_fill_word    = r_fill_word;
        n_fill_wib     = r_fill_wib;
        n_fill_block   = r_fill_block;
        n_drain_block  = r_drain_block;
        n_drain_base   = r_drain_base;
        n_armed        = armed_upd;
        n_need         = need_a;
        n_started      = started_a;
        n_frame_active = fa_upd;
        n_next_addr    = na_a;
        n_frame_start  = fs_a;
        n_rd_left      = r_rd_left;
        n_rd_pend      = r_rd_pend;
        n_out_valid    = r_out_valid;
        n_asm          = r_asm;
        n_rd_ptr       = r_rd_ptr;
        n_rd_addr      = r_rd_addr;
        n_pend_addr    = r_pend_addr;
        n_pend_last    = r_pend_last;
        n_burst_done   = r_burst_done;
        n_out_addr     = r_out_addr;
        n_out_data     = r_out_data;
        n_out_last     = r_out_last;
        n_out_done     = r_out_done;

        // Pixel packing, first pixel in the lowest byte
        if (is_pix && fv && lv) begin
            n_lane = r_lane + 2'd1;
            case (r_lane)
                2'd0:    n_asm[7:0]   = px;
                2'd1:    n_asm[15:8]  = px;
                2'd2:    n_asm[23:16] = px;
                default: begin
                    n_fill_word = (r_fill_word == LAST_WORD) ? '0 : r_fill_word + AW'(1);
                    if (r_fill_wib == LAST_WIB) begin
                        n_fill_wib   = '0;
                        n_fill_block = (r_fill_block == LAST_BLOCK) ? '0
                                                                    : r_fill_block + BW'(1);
                    end else begin
                        n_fill_wib = r_fill_wib + CW'(1);
                    end
                end
            endcase
        end

        // Drain start: advance ring and frame address
        if (drain_go) begin
            n_state       = ST_BURST;
            n_rd_ptr      = r_drain_base;
            n_rd_addr     = na_a;
            n_rd_left     = BURST_LEN;
            n_burst_done  = done;
            n_next_addr   = next_end;
            n_drain_block = (r_drain_block == LAST_BLOCK) ? '0 : r_drain_block + BW'(1);
            n_drain_base  = (r_drain_block == LAST_BLOCK) ? '0 : r_drain_base + BLOCK_STEP;
            if (done) begin
                n_need  = 1'b1;
                n_armed = 1'b0;
            end
        end

        // Output register
        if (load_out) begin
            n_out_valid = 1'b1;
            n_out_addr  = r_pend_addr;
            n_out_data  = i_rd_data;
            n_out_last  = r_pend_last;
            n_out_done  = r_pend_last && r_burst_done;
            n_rd_pend   = 1'b0;
        end else if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        // Store read issue
        if (issue) begin
            n_rd_pend   = 1'b1;
            n_pend_addr = r_rd_addr;
            n_pend_last = (r_rd_left == LW'(1));
            n_rd_ptr    = r_rd_ptr + AW'(1);
            n_rd_addr   = r_rd_addr + ADDR_W'(4);
            n_rd_left   = r_rd_left - LW'(1);
        end

        // Burst ends when its last word is taken
        if (r_out_valid && i_m_tready && r_out_last) begin
            n_state = ST_IDLE;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_lane         <= '0;
            r_fill_word    <= '0;
            r_fill_wib     <= '0;
            r_fill_block   <= '0;
            r_drain_block  <= '0;
            r_drain_base   <= '0;
            r_armed        <= 1'b0;
            r_need         <= 1'b1;
            r_started      <= 1'b0;
            r_frame_active <= 1'b0;
            r_next_addr    <= '0;
            r_frame_start  <= '0;
            r_rd_left      <= '0;
            r_rd_pend      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_lane         <= n_lane;
            r_fill_word    <= n_fill_word;
            r_fill_wib     <= n_fill_wib;
            r_fill_block   <= n_fill_block;
            r_drain_block  <= n_drain_block;
            r_drain_base   <= n_drain_base;
            r_armed        <= n_armed;
            r_need         <= n_need;
            r_started      <= n_started;
            r_frame_active <= n_frame_active;
            r_next_addr    <= n_next_addr;
            r_frame_start  <= n_frame_start;
            r_rd_left      <= n_rd_left;
            r_rd_pend      <= n_rd_pend;
            r_out_valid    <= n_out_valid;
        end
        r_asm        <= n_asm;
        r_rd_ptr     <= n_rd_ptr;
        r_rd_addr    <= n_rd_addr;
        r_pend_addr  <= n_pend_addr;
        r_pend_last  <= n_pend_last;
        r_burst_done <= n_burst_done;
        r_out_addr   <= n_out_addr;
        r_out_data   <= n_out_data;
        r_out_last   <= n_out_last;
        r_out_done   <= n_out_done;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_data, r_out_addr};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_done;

endmodule
`default_nettype wire

[rtl/video_capture_block_dma.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// video_capture_block_dma
// Video capture DMA: packs pixels into a ring of word blocks held in a
// store memory and drains filled blocks as bursts of word writes.
// ----------------------------------------------------------------------------
// Pixel and arm transactions leave tready high.
// A drain transaction that finds a filled block starts a burst of
// WORDS_PER_BLOCK words, read by the single store read port into the
// output register: one word per cycle while the write stream is not stalled.
// Requests are held off until the last word of the burst is taken.
// Reset is synchronous, active low; the store is not cleared.
module video_capture_block_dma #(
    parameter int WORDS_PER_BLOCK = vcbd_pkg::WORDS_PER_BLOCK_DEF,
    parameter int BLOCKS          = vcbd_pkg::BLOCKS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // requests
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,  // fval[0], lval[1], pixel[9:2]
    input  wire logic [1:0]  i_s_axis_tuser,  // req_type[1:0]
    // memory writes
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [63:0] o_m_axis_tdata,  // wr_addr[31:0], wr_data[63:32]
    output logic             o_m_axis_tlast,  // last
    output logic             o_m_axis_tuser   // frame_done[0]
);
    import vcbd_pkg::*;

    localparam int STORE_WORDS = WORDS_PER_BLOCK * BLOCKS;
    localparam int AW          = $clog2(STORE_WORDS);

    logic [ADDR_W-1:0]   r_dest_addr;
    logic [FBYTES_W-1:0] r_frame_bytes;
    logic [ADDR_W-1:0]   r_ram_end;
    t_cfg                cfg;

    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [WORD_W-1:0] wr_data, rd_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_addr   <= DEST_ADDR_RST;
            r_frame_bytes <= FRAME_BYTES_RST;
            r_ram_end     <= RAM_END_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEST_ADDR:   r_dest_addr   <= i_cfg_data;
                CFG_FRAME_BYTES: r_frame_bytes <= i_cfg_data[FBYTES_W-1:0];
                CFG_RAM_END:     r_ram_end     <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign cfg.dest_addr   = r_dest_addr;
    assign cfg.frame_bytes = r_frame_bytes;
    assign cfg.ram_end     = r_ram_end;

    vcbd_ctrl #(
        .WORDS_PER_BLOCK (WORDS_PER_BLOCK),
        .BLOCKS          (BLOCKS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast),
        .o_m_tuser  (o_m_axis_tuser),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

    vcbd_store #(
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule
`default_nettype wire

[rtl/vcbd_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vcbd_checker
// Port-level checks of the capture DMA, bound to the top level.
// ----------------------------------------------------------------------------
module vcbd_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_s_tready,
    input wire logic i_m_tvalid,
    input wire logic i_m_tready,
    input wire logic [63:0] i_m_tdata,
    input wire logic i_m_tlast,
    input wire logic i_m_tuser
);

    // A stalled write transaction holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
            && $stable(i_m_tlast) && $stable(i_m_tuser))
        else $error("write transaction changed while stalled");

    // Requests are held off while a burst word is pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> !i_s_tready)
        else $error("request accepted during a burst");

    // Frame completion only on the final word of a burst
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser |-> i_m_tlast)
        else $error("frame_done without last");

    // Requests resume right after the final word is taken
    a_resume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tready && i_m_tlast |=> i_s_tready && !i_m_tvalid)
        else $error("requests not resumed after burst");

endmodule

bind video_capture_block_dma vcbd_checker u_vcbd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tlast  (o_m_axis_tlast),
    .i_m_tuser  (o_m_axis_tuser)
);
`default_nettype wire
